// ===== src/utf8_decoder_with_replacement_macros.svh =====
// Assertion macros shared by the UTF-8 decoder RTL.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef UTF8_DECODER_WITH_REPLACEMENT_MACROS_SVH
`define UTF8_DECODER_WITH_REPLACEMENT_MACROS_SVH

// Property checked at every clock edge outside of reset.
`define U8D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define U8D_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== src/utf8d_pkg.sv =====
// Shared types and constants for the UTF-8 decoder with replacement.
// No dependencies; used by every module of the decoder.
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

  localparam int WIN_DEPTH = 4;
  localparam int FILL_W    = 3;
  localparam int CP_W      = 21;

  localparam logic [CP_W-1:0] REPL_CP      = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO      = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI      = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_2BYTE    = 21'h000080;
  localparam logic [CP_W-1:0] MIN_3BYTE    = 21'h000800;
  localparam logic [CP_W-1:0] MIN_4BYTE    = 21'h010000;

  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] PAT_CONT   = 8'h80;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] PAT_LEAD2  = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] PAT_LEAD3  = 8'hE0;
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] PAT_LEAD4  = 8'hF0;
  localparam logic [7:0] ASCII_LIM  = 8'h80;

  typedef logic [WIN_DEPTH-1:0][7:0] win_bytes_t;

  typedef enum logic [1:0] {
    ACT_EMPTY,
    ACT_WAIT,
    ACT_HALT,
    ACT_EMIT
  } dec_act_t;

  typedef struct packed {
    dec_act_t          act;
    logic [CP_W-1:0]   cp;
    logic              repl;
    logic [FILL_W-1:0] drop;
  } dec_res_t;

  typedef struct packed {
    logic              append;
    logic [7:0]        data;
    logic              drop;
    logic [FILL_W-1:0] drop_cnt;
    logic              clear;
  } win_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_t;

endpackage

`default_nettype wire

// ===== src/utf8d_window.sv =====
// Four-byte window that buffers an incomplete UTF-8 sequence.
// Depends on utf8d_pkg for the window and control types.
`timescale 1ns / 1ps
`default_nettype none

module utf8d_window (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire utf8d_pkg::win_ctl_t        ctl,
  output utf8d_pkg::win_bytes_t           bytes,
  output logic [utf8d_pkg::FILL_W-1:0]    fill
);

  utf8d_pkg::win_bytes_t          bytes_r;
  utf8d_pkg::win_bytes_t          bytes_nxt;
  logic [utf8d_pkg::FILL_W-1:0]   fill_r;
  logic [utf8d_pkg::FILL_W-1:0]   fill_nxt;

  always_comb begin
    logic [3:0] idx;
    bytes_nxt = bytes_r;
    fill_nxt  = fill_r;
    idx       = '0;
    if (ctl.clear) begin
      fill_nxt = '0;
    end else if (ctl.append) begin
      if (fill_r < utf8d_pkg::FILL_W'(utf8d_pkg::WIN_DEPTH)) begin
        bytes_nxt[fill_r[1:0]] = ctl.data;
        fill_nxt = fill_r + 1'b1;
      end
    end else if (ctl.drop) begin
      // Shift the remaining bytes toward the front.
      for (int j = 0; j < utf8d_pkg::WIN_DEPTH; j++) begin
        idx = 4'(j) + {1'b0, ctl.drop_cnt};
        if (idx < 4'(utf8d_pkg::WIN_DEPTH)) begin
          bytes_nxt[j] = bytes_r[idx[1:0]];
        end
      end
      fill_nxt = fill_r - ctl.drop_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

  assign bytes = bytes_r;
  assign fill  = fill_r;

endmodule

`default_nettype wire

// ===== src/utf8d_decode_unit.sv =====
// Shared decode step: examines the front of the byte window and decides
// one action. Depends on utf8d_pkg for types and constants.
`timescale 1ns / 1ps
`default_nettype none

module utf8d_decode_unit (
  input  wire utf8d_pkg::win_bytes_t         bytes,
  input  wire logic [utf8d_pkg::FILL_W-1:0]  fill,
  output utf8d_pkg::dec_res_t                res
);

  always_comb begin
    logic [7:0]                   b0;
    logic [7:0]                   bx;
    logic [utf8d_pkg::FILL_W-1:0] need;
    logic [utf8d_pkg::CP_W-1:0]   cp;
    logic [utf8d_pkg::CP_W-1:0]   lo;
    logic                         bad;
    logic                         nul;
    logic                         done;

    b0   = bytes[0];
    bx   = '0;
    need = '0;
    cp   = '0;
    lo   = '0;
    bad  = 1'b0;
    nul  = 1'b0;
    done = 1'b0;
    res  = '{act: utf8d_pkg::ACT_EMPTY, cp: '0, repl: 1'b0, drop: '0};

    if (fill == '0) begin
      res.act = utf8d_pkg::ACT_EMPTY;
    end else if (b0 == 8'h00) begin
      res.act = utf8d_pkg::ACT_HALT;
    end else if (b0 < utf8d_pkg::ASCII_LIM) begin
      res = '{act: utf8d_pkg::ACT_EMIT, cp: {13'd0, b0}, repl: 1'b0, drop: 3'd1};
    end else begin
      if ((b0 & utf8d_pkg::MASK_LEAD2) == utf8d_pkg::PAT_LEAD2) begin
        need = 3'd2;
        lo   = utf8d_pkg::MIN_2BYTE;
        cp   = {10'd0, b0[4:0], bytes[1][5:0]};
      end else if ((b0 & utf8d_pkg::MASK_LEAD3) == utf8d_pkg::PAT_LEAD3) begin
        need = 3'd3;
        lo   = utf8d_pkg::MIN_3BYTE;
        cp   = {5'd0, b0[3:0], bytes[1][5:0], bytes[2][5:0]};
      end else if ((b0 & utf8d_pkg::MASK_LEAD4) == utf8d_pkg::PAT_LEAD4) begin
        need = 3'd4;
        lo   = utf8d_pkg::MIN_4BYTE;
        cp   = {b0[2:0], bytes[1][5:0], bytes[2][5:0], bytes[3][5:0]};
      end

      if (need == '0) begin
        // Stray continuation byte or a lead byte that is never valid.
        res = '{act: utf8d_pkg::ACT_EMIT, cp: utf8d_pkg::REPL_CP, repl: 1'b1, drop: 3'd1};
      end else if (fill < need) begin
        res.act = utf8d_pkg::ACT_WAIT;
      end else begin
        // The first NUL or non-continuation byte, in order, decides.
        for (int k = 1; k < utf8d_pkg::WIN_DEPTH; k++) begin
          bx = bytes[k];
          if (!done && (3'(k) < need)) begin
            if (bx == 8'h00) begin
              nul  = 1'b1;
              done = 1'b1;
            end else if ((bx & utf8d_pkg::MASK_CONT) != utf8d_pkg::PAT_CONT) begin
              bad  = 1'b1;
              done = 1'b1;
            end
          end
        end
        if (!bad && ((cp < lo) || (cp > utf8d_pkg::CP_MAX) ||
                     ((cp >= utf8d_pkg::SURR_LO) && (cp <= utf8d_pkg::SURR_HI)))) begin
          bad = 1'b1;
        end
        if (nul) begin
          res.act = utf8d_pkg::ACT_HALT;
        end else if (bad) begin
          res = '{act: utf8d_pkg::ACT_EMIT, cp: utf8d_pkg::REPL_CP, repl: 1'b1,
                  drop: 3'd1};
        end else begin
          res = '{act: utf8d_pkg::ACT_EMIT, cp: cp, repl: 1'b0, drop: need};
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/utf8_decoder_with_replacement.sv =====
// An ASCII byte passes from the window through the pending slot to the output register, under the
// sequencer states idle, run and flush. A new byte is taken only in the idle state, so each byte
// is decoded to its code points before the next one is accepted; the single decode unit is used
// once per code point under the sequencer.
// A stalled output register holds the sequencer whenever a word must be handed over.
// Reset (rst_n, synchronous, active low) empties the window and clears the stop flag,
// the pending slot and the output valid; buffered byte values are left as they are.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_decoder_with_replacement_macros.svh"

module utf8_decoder_with_replacement (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Byte input channel.
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [7:0]                   in_text_byte,
  input  wire logic                         in_final_byte,
  // Code point output channel.
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [utf8d_pkg::CP_W-1:0]        out_code_point,
  output logic                              out_replaced,
  output logic                              out_has_char,
  output logic                              out_end_of_text,
  output logic                              out_last_in_run
);

  // Sequencer state.
  utf8d_pkg::state_t              state_r, state_nxt;
  logic                           fin_r, fin_nxt;
  logic                           stopped_r, stopped_nxt;

  // One decoded code point is parked here until we know whether it is the
  // last word caused by the current byte; only then are its flags final.
  logic                           pend_valid_r, pend_valid_nxt;
  logic [utf8d_pkg::CP_W-1:0]     pend_cp_r, pend_cp_nxt;
  logic                           pend_repl_r, pend_repl_nxt;

  // Output register, which separates the sequencer from the output stall.
  logic                           out_valid_r;
  logic [utf8d_pkg::CP_W-1:0]     out_cp_r;
  logic                           out_repl_r;
  logic                           out_has_r;
  logic                           out_eot_r;
  logic                           out_last_r;

  logic                           out_load;
  logic [utf8d_pkg::CP_W-1:0]     load_cp;
  logic                           load_repl;
  logic                           load_has;
  logic                           load_eot;
  logic                           load_last;
  logic                           out_free;

  utf8d_pkg::win_ctl_t            win_ctl;
  utf8d_pkg::win_bytes_t          win_bytes;
  logic [utf8d_pkg::FILL_W-1:0]   win_fill;
  utf8d_pkg::dec_res_t            dec;

  utf8d_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (win_ctl),
    .bytes (win_bytes),
    .fill  (win_fill)
  );

  utf8d_decode_unit u_decode (
    .bytes (win_bytes),
    .fill  (win_fill),
    .res   (dec)
  );

  // The output register can take a word when it is empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != utf8d_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= utf8d_pkg::ST_IDLE;
      fin_r        <= 1'b0;
      stopped_r    <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fin_r        <= fin_nxt;
      stopped_r    <= stopped_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_cp_r   <= pend_cp_nxt;
    pend_repl_r <= pend_repl_nxt;
  end

  // Next state, window control and output loading.
  always_comb begin
    state_nxt      = state_r;
    fin_nxt        = fin_r;
    stopped_nxt    = stopped_r;
    pend_valid_nxt = pend_valid_r;
    pend_cp_nxt    = pend_cp_r;
    pend_repl_nxt  = pend_repl_r;
    win_ctl        = '0;
    win_ctl.data   = in_text_byte;
    out_load       = 1'b0;
    load_cp        = pend_cp_r;
    load_repl      = pend_repl_r;
    load_has       = 1'b1;
    load_eot       = 1'b0;
    load_last      = 1'b0;

    case (state_r)
      utf8d_pkg::ST_IDLE: begin
        if (in_valid) begin
          fin_nxt = in_final_byte;
          if (stopped_r) begin
            // Bytes after a stop are dropped; the final byte still closes the text.
            if (in_final_byte) begin
              state_nxt = utf8d_pkg::ST_FLUSH;
            end
          end else begin
            win_ctl.append = 1'b1;
            state_nxt      = utf8d_pkg::ST_RUN;
          end
        end
      end

      utf8d_pkg::ST_RUN: begin
        case (dec.act)
          utf8d_pkg::ACT_EMIT: begin
            // A new code point pushes the parked one out as a non-final word.
            if (!pend_valid_r || out_free) begin
              out_load         = pend_valid_r;
              pend_valid_nxt   = 1'b1;
              pend_cp_nxt      = dec.cp;
              pend_repl_nxt    = dec.repl;
              win_ctl.drop     = 1'b1;
              win_ctl.drop_cnt = dec.drop;
            end
          end
          utf8d_pkg::ACT_HALT: begin
            win_ctl.clear = 1'b1;
            stopped_nxt   = 1'b1;
            state_nxt     = utf8d_pkg::ST_FLUSH;
          end
          utf8d_pkg::ACT_WAIT: begin
            // An incomplete sequence at the end of the text stops decoding.
            if (fin_r) begin
              win_ctl.clear = 1'b1;
              stopped_nxt   = 1'b1;
            end
            state_nxt = utf8d_pkg::ST_FLUSH;
          end
          default: begin
            state_nxt = utf8d_pkg::ST_FLUSH;
          end
        endcase
      end

      utf8d_pkg::ST_FLUSH: begin
        if (pend_valid_r || fin_r) begin
          if (out_free) begin
            // The parked code point is the last word of this byte; with no
            // code point at all, the final byte gives a bare end marker.
            out_load       = 1'b1;
            load_cp        = pend_valid_r ? pend_cp_r : '0;
            load_repl      = pend_valid_r & pend_repl_r;
            load_has       = pend_valid_r;
            load_eot       = fin_r;
            load_last      = 1'b1;
            pend_valid_nxt = 1'b0;
            if (fin_r) begin
              win_ctl.clear = 1'b1;
              stopped_nxt   = 1'b0;
              fin_nxt       = 1'b0;
            end
            state_nxt = utf8d_pkg::ST_IDLE;
          end
        end else begin
          state_nxt = utf8d_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = utf8d_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cp_r   <= load_cp;
      out_repl_r <= load_repl;
      out_has_r  <= load_has;
      out_eot_r  <= load_eot;
      out_last_r <= load_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_code_point  = out_cp_r;
  assign out_replaced    = out_repl_r;
  assign out_has_char    = out_has_r;
  assign out_end_of_text = out_eot_r;
  assign out_last_in_run = out_last_r;

  // Once stopped, nothing may remain buffered in the window.
  `U8D_ASSERT(a_stop_empty, stopped_r |-> (win_fill == '0), "window not empty while stopped")
  // The parked code point never survives into the idle state.
  `U8D_ASSERT(a_pend_idle, pend_valid_r |-> (state_r != utf8d_pkg::ST_IDLE), "pending word lost")
  // The decode step never consumes more bytes than are buffered.
  `U8D_ASSERT(a_drop_fill,
              (dec.act == utf8d_pkg::ACT_EMIT) |-> (dec.drop <= win_fill),
              "drop exceeds fill")
  // A flush that finds the output free hands the parked word over.
  `U8D_ASSERT_NEXT(a_flush_done,
                   (state_r == utf8d_pkg::ST_FLUSH) && out_free,
                   !pend_valid_r && (state_r == utf8d_pkg::ST_IDLE),
                   "flush did not complete")

endmodule

`default_nettype wire

// ===== test/tb_utf8_decoder_with_replacement.sv =====
// Self-checking testbench for the UTF-8 decoder with replacement.
// Needs only the decoder RTL and its package utf8d_pkg.
`timescale 1ns / 1ps

module tb_utf8_decoder_with_replacement;

  // Cycles without any handshake before the run is declared hung.
  localparam int HANG_LIMIT = 1000;
  // Cycles to keep watching the output after the last expected word.
  localparam int TAIL_CYCLES = 12;
  // Accepted, non-ignored bytes wanted from the random part.
  localparam int RANDOM_BYTES = 420;

  // One decoded word as it leaves the output channel.
  typedef struct packed {
    logic [utf8d_pkg::CP_W-1:0] code_point;
    logic                       replaced;
    logic                       has_char;
    logic                       end_of_text;
    logic                       last_in_run;
  } cp_word_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [7:0]                 in_text_byte = 8'h00;
  logic                       in_final_byte = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [utf8d_pkg::CP_W-1:0] out_code_point;
  logic                       out_replaced;
  logic                       out_has_char;
  logic                       out_end_of_text;
  logic                       out_last_in_run;

  utf8_decoder_with_replacement dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_text_byte   (in_text_byte),
    .in_final_byte  (in_final_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_replaced   (out_replaced),
    .out_has_char   (out_has_char),
    .out_end_of_text(out_end_of_text),
    .out_last_in_run(out_last_in_run)
  );

  always #6 clk = ~clk;

  // Words the decoder must still produce, oldest first.
  cp_word_t   expected_words[$];
  // Bytes of the text that is being built and then sent.
  logic [7:0] text_q[$];

  // Shadow copy of the decoder state: the byte window, its fill level and
  // the stop flag that is set by a NUL or by a truncated final sequence.
  logic [7:0] shadow_win[utf8d_pkg::WIN_DEPTH];
  int         shadow_fill = 0;
  bit         shadow_halted = 1'b0;

  int fail_count = 0;
  int useful_bytes = 0;
  int burst_left = 0;
  int hang_count = 0;

  // Removes the k oldest bytes from the shadow window.
  task automatic shift_window(input int k);
    int j;
    if (k > shadow_fill) k = shadow_fill;
    for (j = 0; j + k < shadow_fill; j++) shadow_win[j] = shadow_win[j + k];
    shadow_fill = shadow_fill - k;
  endtask

  task automatic push_word(inout cp_word_t run[$], input logic [utf8d_pkg::CP_W-1:0] cp,
                           input logic repl, input logic has);
    cp_word_t w;
    w.code_point  = cp;
    w.replaced    = repl;
    w.has_char    = has;
    w.end_of_text = 1'b0;
    w.last_in_run = 1'b0;
    run.push_back(w);
  endtask

  // Works out the words caused by one accepted byte and queues them.
  // The counted flag is low for a byte that the decoder simply drops
  // because it is stopped and the text has not ended yet.
  task automatic decode_byte(input logic [7:0] b, input bit fin, output bit counted);
    cp_word_t                   run[$];
    cp_word_t                   w;
    logic [7:0]                 lead;
    logic [7:0]                 bx;
    logic [utf8d_pkg::CP_W-1:0] cp;
    logic [utf8d_pkg::CP_W-1:0] lo;
    int                         need;
    int                         k;
    bit                         bad;
    bit                         waiting;
    counted = !shadow_halted || fin;
    waiting = 1'b0;
    if (!shadow_halted) begin
      if (shadow_fill < utf8d_pkg::WIN_DEPTH) begin
        shadow_win[shadow_fill] = b;
        shadow_fill++;
      end
      while (!waiting && shadow_fill > 0 && !shadow_halted && run.size() < 4) begin
        lead = shadow_win[0];
        need = 0;
        if (lead == 8'h00) begin
          shadow_fill = 0;
          shadow_halted = 1'b1;
        end else if (lead < utf8d_pkg::ASCII_LIM) begin
          push_word(run, utf8d_pkg::CP_W'(lead), 1'b0, 1'b1);
          shift_window(1);
        end else if ((lead & utf8d_pkg::MASK_CONT) == utf8d_pkg::PAT_CONT) begin
          push_word(run, utf8d_pkg::REPL_CP, 1'b1, 1'b1);
          shift_window(1);
        end else begin
          if ((lead & utf8d_pkg::MASK_LEAD2) == utf8d_pkg::PAT_LEAD2) begin
            need = 2; cp = utf8d_pkg::CP_W'(lead & 8'h1F); lo = utf8d_pkg::MIN_2BYTE;
          end else if ((lead & utf8d_pkg::MASK_LEAD3) == utf8d_pkg::PAT_LEAD3) begin
            need = 3; cp = utf8d_pkg::CP_W'(lead & 8'h0F); lo = utf8d_pkg::MIN_3BYTE;
          end else if ((lead & utf8d_pkg::MASK_LEAD4) == utf8d_pkg::PAT_LEAD4) begin
            need = 4; cp = utf8d_pkg::CP_W'(lead & 8'h07); lo = utf8d_pkg::MIN_4BYTE;
          end
          if (need == 0) begin
            push_word(run, utf8d_pkg::REPL_CP, 1'b1, 1'b1);
            shift_window(1);
          end else if (shadow_fill < need) begin
            // A truncated sequence on the final byte stops decoding at once.
            if (fin) begin
              shadow_fill = 0;
              shadow_halted = 1'b1;
            end
            waiting = 1'b1;
          end else begin
            bad = 1'b0;
            k = 1;
            while (k < need && !shadow_halted && !bad) begin
              bx = shadow_win[k];
              if (bx == 8'h00) begin
                shadow_fill = 0;
                shadow_halted = 1'b1;
              end else if ((bx & utf8d_pkg::MASK_CONT) != utf8d_pkg::PAT_CONT) begin
                bad = 1'b1;
              end else begin
                cp = (cp << 6) | utf8d_pkg::CP_W'(bx & 8'h3F);
              end
              k++;
            end
            if (!shadow_halted) begin
              if (!bad && (cp < lo || cp > utf8d_pkg::CP_MAX ||
                           (cp >= utf8d_pkg::SURR_LO && cp <= utf8d_pkg::SURR_HI)))
                bad = 1'b1;
              // A bad sequence replaces only its lead byte; the rest is rescanned.
              if (bad) begin
                push_word(run, utf8d_pkg::REPL_CP, 1'b1, 1'b1);
                shift_window(1);
              end else begin
                push_word(run, cp, 1'b0, 1'b1);
                shift_window(need);
              end
            end
          end
        end
      end
    end
    if (fin) begin
      // The final byte always yields at least a bare end marker.
      if (run.size() == 0) push_word(run, '0, 1'b0, 1'b0);
      w = run.pop_back();
      w.end_of_text = 1'b1;
      run.push_back(w);
      shadow_fill = 0;
      shadow_halted = 1'b0;
    end
    if (run.size() > 0) begin
      w = run.pop_back();
      w.last_in_run = 1'b1;
      run.push_back(w);
    end
    foreach (run[i]) expected_words.push_back(run[i]);
  endtask

  // Drives one byte, holds it until it is accepted, then predicts its words.
  // It is entered and left at a falling edge; valid stays high afterwards so
  // that back-to-back bytes never lower and raise it in the same step.
  task automatic send_byte(input logic [7:0] b, input bit fin);
    int gap;
    bit counted;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      // Mostly short bursts, now and then a long stretch with no gaps.
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_text_byte  <= b;
    in_final_byte <= fin;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    decode_byte(b, fin, counted);
    if (counted) useful_bytes++;
    @(negedge clk);
  endtask

  // Sends the built text with the final flag on its last byte.
  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  // Appends cp encoded in len bytes, whether or not that form is legal.
  task automatic put_raw(input logic [20:0] cp, input int len);
    case (len)
      1: text_q.push_back({1'b0, cp[6:0]});
      2: begin
        text_q.push_back({3'b110, cp[10:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        text_q.push_back({4'b1110, cp[15:12]});
        text_q.push_back({2'b10, cp[11:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        text_q.push_back({5'b11110, cp[20:18]});
        text_q.push_back({2'b10, cp[17:12]});
        text_q.push_back({2'b10, cp[11:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Picks a legal scalar value that needs exactly len bytes.
  function automatic logic [20:0] legal_cp(input int len);
    logic [20:0] cp;
    case (len)
      1: cp = 21'($urandom_range(1, 8'h7F));
      2: cp = 21'($urandom_range(8'h80, 16'h7FF));
      3: begin
        cp = 21'($urandom_range(16'h800, 16'hFFFF));
        if (cp >= utf8d_pkg::SURR_LO && cp <= utf8d_pkg::SURR_HI) cp = cp ^ 21'h001000;
      end
      default: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
    endcase
    return cp;
  endfunction

  // Appends one random character: mostly well formed, the rest malformed.
  task automatic put_random_char();
    int          r;
    int          len;
    int          keep;
    logic [7:0]  brk;
    r = $urandom_range(0, 99);
    len = $urandom_range(2, 4);
    if (r < 35) put_raw(legal_cp(1), 1);
    else if (r < 72) put_raw(legal_cp(len), len);
    else if (r < 76) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
    else if (r < 79) text_q.push_back(8'($urandom_range(8'hF8, 8'hFF)));
    else if (r < 82) begin
      // Overlong form: a value that would fit in fewer bytes.
      case (len)
        2: put_raw(21'($urandom_range(0, 8'h7F)), 2);
        3: put_raw(21'($urandom_range(0, 16'h7FF)), 3);
        default: put_raw(21'($urandom_range(0, 16'hFFFF)), 4);
      endcase
    end else if (r < 85) put_raw(21'($urandom_range(16'hD800, 16'hDFFF)), 3);
    else if (r < 88) put_raw(21'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
    else if (r < 96) begin
      // Broken sequence: the continuation bytes are cut short by a non-continuation.
      put_raw(legal_cp(len), len);
      keep = $urandom_range(0, len - 2);
      repeat (len - 1 - keep) void'(text_q.pop_back());
      brk = 8'($urandom_range(0, 8'hFF));
      if ((brk & utf8d_pkg::MASK_CONT) == utf8d_pkg::PAT_CONT) brk = brk ^ 8'h40;
      text_q.push_back(brk);
    end else if (r < 98) text_q.push_back(8'($urandom_range(0, 8'hFF)));
    else text_q.push_back(8'h00);
  endtask

  // Full legal extremes of each length; the text ends on the largest value.
  task automatic test_legal_extremes();
    text_q = '{8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_text();
  endtask

  // Stray continuation, bad lead, overlong, broken continuation, surrogate
  // and a value above the Unicode range. The last two release several words
  // from one byte because the trailing bytes are rescanned as lead bytes.
  task automatic test_malformed();
    text_q = '{8'h80, 8'hF8, 8'hC1, 8'hBF, 8'hE2, 8'h41, 8'h42,
               8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80};
    send_text();
  endtask

  // A NUL as a lead byte and as a continuation byte both stop decoding, so
  // the final byte only yields a bare end marker.
  task automatic test_nul_stop();
    text_q = '{8'h00, 8'h41};
    send_text();
    text_q = '{8'hC3, 8'h00};
    send_text();
  endtask

  // A text that ends in the middle of a sequence.
  task automatic test_truncated_end();
    text_q = '{8'hE2, 8'h82};
    send_text();
  endtask

  // Random texts of random characters, some cut short at the end.
  task automatic test_random_text();
    int n;
    int len;
    useful_bytes = 0;
    while (useful_bytes < RANDOM_BYTES) begin
      n = $urandom_range(1, 16);
      repeat (n) put_random_char();
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(2, 4);
        put_raw(legal_cp(len), len);
        repeat ($urandom_range(1, len - 1)) void'(text_q.pop_back());
      end
      send_text();
    end
  endtask

  // The receiver stalls in phases: none, light, heavy, or a solid stretch.
  int stall_mode = 0;
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = (stall_mode == 3) ? $urandom_range(2, 10) : $urandom_range(4, 40);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= 1'b1;
    endcase
  end

  // Every accepted word is compared with the oldest expected one.
  always @(posedge clk) begin
    cp_word_t got;
    cp_word_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = {out_code_point, out_replaced, out_has_char, out_end_of_text, out_last_in_run};
      if (expected_words.size() == 0) begin
        if (fail_count < 10)
          $display("%0t: unexpected word cp=%h repl=%b has=%b eot=%b last=%b", $realtime,
                   got.code_point, got.replaced, got.has_char, got.end_of_text,
                   got.last_in_run);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          if (fail_count < 10)
            $display("%0t: exp cp=%h r=%b h=%b e=%b l=%b got cp=%h r=%b h=%b e=%b l=%b",
                     $realtime,
                     want.code_point, want.replaced, want.has_char, want.end_of_text,
                     want.last_in_run, got.code_point, got.replaced, got.has_char,
                     got.end_of_text, got.last_in_run);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on handshakes of either channel.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      hang_count = 0;
    else
      hang_count++;
    if (hang_count >= HANG_LIMIT) begin
      $display("FAIL utf8_decoder_with_replacement");
      $finish;
    end
  end

  initial begin
    // Hold reset, then release it at a falling edge, where all stimulus changes.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_legal_extremes();
    test_malformed();
    test_nul_stop();
    test_truncated_end();
    test_random_text();

    // Stop driving, let every expected word drain, and then keep watching
    // a little longer for stray words.
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS utf8_decoder_with_replacement");
    end else begin
      $display("FAIL utf8_decoder_with_replacement");
    end
    $finish;
  end

endmodule
